@@ sv/tlg_pkg.sv @@
//------------------------------------------------------------------------------
// tlg_pkg
// Shared types and constants of the toroidal Life grid engine.
//------------------------------------------------------------------------------
`default_nettype none

package tlg_pkg;

   localparam int GRID_WIDTH  = 32;
   localparam int GRID_HEIGHT = 32;
   localparam int COL_W       = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
   localparam int ROW_W       = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
   localparam int ACC_W       = $clog2(GRID_WIDTH * GRID_HEIGHT + 1);
   localparam int ROWCNT_W    = $clog2(GRID_WIDTH + 1);
   localparam int POS_W       = 5;
   localparam int POSX_W      = 9;
   localparam int BIRTH_W     = 4;
   localparam int POP_W       = 11;
   localparam int POP_MAX     = 2047;
   localparam int BIRTH_RESET = 3;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STEP  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_COUNT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic apply;
      logic count_clear;
      logic count_row;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic row_last;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

@@ sv/tlg_ctrl.sv @@
//------------------------------------------------------------------------------
// tlg_ctrl
// Sequencer: accepts a request, applies it, counts the grid row by row and
// hands the result to the response register.
//------------------------------------------------------------------------------
`default_nettype none

module tlg_ctrl import tlg_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply       = 1'b1;
            cmd.count_clear = 1'b1;
            state_in        = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.count_row = 1'b1;
            if (status.row_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_accept_apply: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_APPLY)
      else $error("accepted beat did not start apply");
   a_apply_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPLY |=> state_ff == ST_COUNT)
      else $error("apply not followed by count");
   a_count_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT && status.row_last) |=> state_ff == ST_DONE)
      else $error("count did not finish");

endmodule

`default_nettype wire

@@ sv/tlg_datapath.sv @@
//------------------------------------------------------------------------------
// tlg_datapath
// Cell array with next-generation logic, row-serial population counter,
// request capture and response register.
//------------------------------------------------------------------------------
`default_nettype none

module tlg_datapath import tlg_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  wire  [1:0]         req_operation,
   input  wire  [POS_W-1:0]   req_x_pos,
   input  wire  [POS_W-1:0]   req_y_pos,
   input  wire                req_write_value,
   input  wire                csr_write_enable,
   input  wire  [BIRTH_W-1:0] csr_write_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic               rsp_cell_state,
   output logic [POP_W-1:0]   rsp_population
);

   logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] grid_ff, grid_in, next_grid;
   logic [BIRTH_W-1:0] birth_ff;
   op_type             op_ff;
   logic [POSX_W-1:0]  x_ff, y_ff;
   logic               v_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic               rsp_valid_ff;
   logic               rsp_cell_ff;
   logic [POP_W-1:0]   rsp_pop_ff;
   logic               in_grid;
   logic [COL_W-1:0]   col;
   logic [ROW_W-1:0]   row_sel;
   logic [ROWCNT_W-1:0] row_ones;
   logic [POP_W-1:0]   pop_sat;

   assign in_grid = (x_ff < POSX_W'(GRID_WIDTH)) && (y_ff < POSX_W'(GRID_HEIGHT));
   assign col     = x_ff[COL_W-1:0];
   assign row_sel = y_ff[ROW_W-1:0];
   assign row_ones = ROWCNT_W'($countones(grid_ff[row_ff]));
   assign pop_sat = (acc_ff > ACC_W'(POP_MAX)) ? POP_W'(POP_MAX) : POP_W'(acc_ff);

   always_comb begin
      int up, dn, lf, rt;
      logic [3:0] n;
      next_grid = '0;
      for (int r = 0; r < GRID_HEIGHT; r++) begin
         for (int c = 0; c < GRID_WIDTH; c++) begin
            up = (r == 0) ? GRID_HEIGHT - 1 : r - 1;
            dn = (r == GRID_HEIGHT - 1) ? 0 : r + 1;
            lf = (c == 0) ? GRID_WIDTH - 1 : c - 1;
            rt = (c == GRID_WIDTH - 1) ? 0 : c + 1;
            n = 4'(grid_ff[up][lf]) + 4'(grid_ff[up][c]) + 4'(grid_ff[up][rt])
              + 4'(grid_ff[r][lf]) + 4'(grid_ff[r][rt])
              + 4'(grid_ff[dn][lf]) + 4'(grid_ff[dn][c]) + 4'(grid_ff[dn][rt]);
            if (grid_ff[r][c]) begin
               next_grid[r][c] = (n == 4'd2) || (n == 4'd3);
            end else begin
               next_grid[r][c] = (n == birth_ff);
            end
         end
      end
   end

   always_comb begin
      grid_in = grid_ff;
      if (cmd.apply) begin
         if (op_ff == OP_STEP) begin
            grid_in = next_grid;
         end else if (op_ff == OP_WRITE && in_grid) begin
            grid_in[row_sel][col] = v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff      <= '0;
         birth_ff     <= BIRTH_W'(BIRTH_RESET);
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else begin
         grid_ff <= grid_in;
         if (csr_write_enable) begin
            birth_ff <= csr_write_data;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.count_clear) begin
            row_ff <= '0;
         end else if (cmd.count_row) begin
            row_ff <= row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= op_type'(req_operation);
         x_ff  <= POSX_W'(req_x_pos);
         y_ff  <= POSX_W'(req_y_pos);
         v_ff  <= req_write_value;
      end
      if (cmd.count_clear) begin
         acc_ff <= '0;
      end else if (cmd.count_row) begin
         acc_ff <= acc_ff + ACC_W'(row_ones);
      end
      if (cmd.load_rsp) begin
         rsp_cell_ff <= in_grid ? grid_ff[row_sel][col] : 1'b0;
         rsp_pop_ff  <= pop_sat;
      end
   end

   assign status.row_last = (row_ff == ROW_W'(GRID_HEIGHT - 1));
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_state  = rsp_cell_ff;
   assign rsp_population  = rsp_pop_ff;

endmodule

`default_nettype wire

@@ sv/toroidal_life_grid_engine_core.sv @@
//------------------------------------------------------------------------------
// toroidal_life_grid_engine_core
// Toroidal Game of Life grid: write cell, read cell or advance a generation,
// each beat answered with the addressed cell and the live population.
//
//   Channel | Ports                                   | Direction
//   req     | req_valid/ready, operation, x, y, value | in
//   rsp     | rsp_valid/ready, cell_state, population | out
//   csr     | csr_write_enable, csr_write_data        | in
//
// After the accept the sequencer updates the whole cell array, counts the
// population row by row with a single row adder and loads the response
// register. A new request is accepted only once the sequencer is back in
// idle after that load, so each beat is finished before another is taken.
// Reset clears the grid, sets the birth count to three and empties the
// response register. A stalled response holds the sequencer in its final
// state until the register frees.
//------------------------------------------------------------------------------
`default_nettype none

module toroidal_life_grid_engine_core import tlg_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [1:0]         req_operation,
   input  wire  [POS_W-1:0]   req_x_pos,
   input  wire  [POS_W-1:0]   req_y_pos,
   input  wire                req_write_value,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic               rsp_cell_state,
   output logic [POP_W-1:0]   rsp_population,
   input  wire                csr_write_enable,
   input  wire  [BIRTH_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   tlg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlg_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_write_value  (req_write_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cell_state   (rsp_cell_state),
      .rsp_population   (rsp_population)
   );

endmodule

`default_nettype wire

@@ verif/toroidal_life_grid_engine_core_test.sv @@
//------------------------------------------------------------------------------
// toroidal_life_grid_engine_core_test
// Checks the toroidal Life grid engine against a behavioral grid kept in the
// testbench: directed cell writes, reads and generations first, then random
// seeded patterns and random traffic under several birth counts, with random
// idling on both channels and one long response stall.
//------------------------------------------------------------------------------
`default_nettype none

module toroidal_life_grid_engine_core_test import tlg_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      op_type            op;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic              value;
   } cmd_beat_type;

   typedef struct packed {
      logic              cell_bit;
      logic [POP_W-1:0]  pop;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_operation = '0;
   logic [POS_W-1:0]   req_x_pos = '0;
   logic [POS_W-1:0]   req_y_pos = '0;
   logic               req_write_value = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_cell_state;
   logic [POP_W-1:0]   rsp_population;
   logic               csr_write_enable = 1'b0;
   logic [BIRTH_W-1:0] csr_write_data = '0;

   cmd_beat_type pending_cmds[$];
   answer_type   expected_answers[$];
   logic      life[GRID_HEIGHT][GRID_WIDTH];
   logic [BIRTH_W-1:0] birth_rule;
   int        errors = 0;
   int        send_idle_pct = 16;
   int        recv_idle_pct = 76;
   int        hold_cycles = 0;

   toroidal_life_grid_engine_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_x_pos(req_x_pos),
      .req_y_pos(req_y_pos), .req_write_value(req_write_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cell_state(rsp_cell_state), .rsp_population(rsp_population),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #10 clock = ~clock;

   function automatic int live_neighbors(int r, int c);
      int total;
      total = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
               total += life[(r + dr + GRID_HEIGHT) % GRID_HEIGHT]
                            [(c + dc + GRID_WIDTH) % GRID_WIDTH];
            end
         end
      end
      return total;
   endfunction

   task automatic apply_command(input cmd_beat_type b);
      logic nxt[GRID_HEIGHT][GRID_WIDTH];
      int n;
      int pop;
      logic in_grid;
      answer_type a;
      in_grid = (b.x < GRID_WIDTH) && (b.y < GRID_HEIGHT);
      if (b.op == OP_WRITE && in_grid) begin
         life[b.y][b.x] = b.value;
      end else if (b.op == OP_STEP) begin
         for (int r = 0; r < GRID_HEIGHT; r++) begin
            for (int c = 0; c < GRID_WIDTH; c++) begin
               n = live_neighbors(r, c);
               if (!life[r][c]) begin
                  nxt[r][c] = (n == birth_rule);
               end else begin
                  nxt[r][c] = !(n < 2 || n > 3);
               end
            end
         end
         life = nxt;
      end
      pop = 0;
      for (int r = 0; r < GRID_HEIGHT; r++) begin
         for (int c = 0; c < GRID_WIDTH; c++) begin
            pop += life[r][c];
         end
      end
      a.cell_bit = in_grid ? life[b.y][b.x] : 1'b0;
      a.pop = (pop > POP_MAX) ? POP_W'(POP_MAX) : POP_W'(pop);
      expected_answers.push_back(a);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      cmd_beat_type b;
      if (!reset) begin
         if (req_valid && req_ready) begin
            apply_command({op_type'(req_operation), req_x_pos, req_y_pos,
                           req_write_value});
         end
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               b = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_operation <= b.op;
               req_x_pos <= b.x;
               req_y_pos <= b.y;
               req_write_value <= b.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            a = expected_answers.pop_front();
            if (rsp_cell_state !== a.cell_bit) begin
               report_mismatch("cell_state", rsp_cell_state, a.cell_bit);
            end
            if (rsp_population !== a.pop) begin
               report_mismatch("population", rsp_population, a.pop);
            end
         end
      end
   end

   task automatic queue_cmd(input op_type op, input int x, input int y, input int v);
      cmd_beat_type b;
      b.op = op;
      b.x = POS_W'(x);
      b.y = POS_W'(y);
      b.value = v[0];
      pending_cmds.push_back(b);
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_valid || expected_answers.size() > 0) begin
         @(posedge clock);
      end
      repeat (GRID_HEIGHT + 10) @(posedge clock);
   endtask

   task automatic set_birth_rule(input int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= BIRTH_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      birth_rule = BIRTH_W'(value);
   endtask

   task automatic random_phase(input int count);
      int k;
      int x0;
      int y0;
      k = 0;
      while (k < count) begin
         if ($urandom_range(3) == 0) begin
            x0 = $urandom_range(31);
            y0 = $urandom_range(31);
            for (int j = 0; j < 8; j++) begin
               queue_cmd(OP_WRITE, (x0 + $urandom_range(3)) % 32,
                         (y0 + $urandom_range(3)) % 32, $urandom_range(1));
            end
            for (int j = 0; j < 4; j++) begin
               queue_cmd(OP_STEP, $urandom_range(31), $urandom_range(31), $urandom_range(1));
            end
            k += 12;
         end else begin
            queue_cmd(op_type'($urandom_range(3)), $urandom_range(31),
                      $urandom_range(31), $urandom_range(1));
            k++;
         end
      end
   endtask

   initial begin
      for (int r = 0; r < GRID_HEIGHT; r++) begin
         for (int c = 0; c < GRID_WIDTH; c++) begin
            life[r][c] = 1'b0;
         end
      end
      birth_rule = BIRTH_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_cmd(OP_READ, 0, 0, 0);
      queue_cmd(OP_WRITE, 31, 31, 1);
      queue_cmd(OP_WRITE, 0, 31, 1);
      queue_cmd(OP_WRITE, 31, 0, 1);
      queue_cmd(OP_WRITE, 0, 0, 3);
      queue_cmd(OP_READ, 31, 31, 0);
      queue_cmd(OP_STEP, 0, 0, 0);
      queue_cmd(OP_NOP, 31, 0, 1);
      queue_cmd(OP_WRITE, 5, 5, 1);
      queue_cmd(OP_WRITE, 6, 5, 1);
      queue_cmd(OP_WRITE, 7, 5, 1);
      queue_cmd(OP_STEP, 6, 4, 0);
      queue_cmd(OP_STEP, 6, 5, 1);
      queue_cmd(OP_WRITE, 5, 5, 0);
      queue_cmd(OP_READ, 6, 6, 1);
      queue_cmd(OP_STEP, 16, 16, 0);
      wait_drained();

      set_birth_rule(0);
      queue_cmd(OP_STEP, 10, 10, 0);
      queue_cmd(OP_STEP, 10, 10, 0);
      queue_cmd(OP_READ, 20, 3, 0);
      wait_drained();
      set_birth_rule(15);
      queue_cmd(OP_STEP, 1, 1, 0);
      queue_cmd(OP_STEP, 2, 2, 0);
      wait_drained();

      set_birth_rule(3);
      hold_cycles = 400;
      random_phase(500);
      wait_drained();

      send_idle_pct = 76;
      recv_idle_pct = 16;
      set_birth_rule(8);
      random_phase(200);
      wait_drained();
      set_birth_rule(2);
      random_phase(300);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_birth_rule($urandom_range(1, 7));
      random_phase(300);
      wait_drained();
      set_birth_rule(3);
      random_phase(300);
      wait_drained();

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/tlg_pkg.sv
sv/tlg_ctrl.sv
sv/tlg_datapath.sv
sv/toroidal_life_grid_engine_core.sv
verif/toroidal_life_grid_engine_core_test.sv
